### hdl/dsf_pkg.sv
// shared types, widths and helpers for the damped 2d spring force pipeline
// no dependencies
package dsf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned MagW  = DataW + 1;
  localparam int unsigned RelW  = DataW + 2;
  localparam int unsigned SumW  = 2 * MagW;
  localparam int unsigned LenW  = MagW;
  localparam int unsigned QW    = FracW + 1;
  localparam int unsigned RestW = DataW - 1;
  localparam int unsigned SatW  = 72;
  localparam int unsigned AddrW = 4;

  localparam logic [LenW-1:0] LenMin = LenW'(((1 << FracW) + 99) / 100);

  localparam logic [1:0] RegRest  = 2'd0;
  localparam logic [1:0] RegStiff = 2'd1;
  localparam logic [1:0] RegDamp  = 2'd2;

  typedef struct packed {
    logic [MagW-1:0]        ax;
    logic [MagW-1:0]        ay;
    logic                   sx;
    logic                   sy;
    logic signed [RelW-1:0] rvx;
    logic signed [RelW-1:0] rvy;
    logic                   fix1;
    logic                   fix2;
  } dsf_side_t;

  typedef struct packed {
    logic                   sx;
    logic                   sy;
    logic signed [RelW-1:0] rvx;
    logic signed [RelW-1:0] rvy;
    logic                   fix1;
    logic                   fix2;
    logic [LenW-1:0]        len;
  } dsf_tail_t;

  typedef struct packed {
    logic [RestW-1:0]        rest;
    logic signed [DataW-1:0] ks;
    logic signed [DataW-1:0] kd;
  } dsf_cfg_t;

  function automatic logic signed [DataW-1:0] sat_out(input logic signed [SatW-1:0] v);
    logic signed [SatW-1:0] mx;
    logic signed [SatW-1:0] mn;
    mx = SatW'(signed'({1'b0, {(DataW-1){1'b1}}}));
    mn = -mx - SatW'(1);
    if (v > mx) begin
      return mx[DataW-1:0];
    end else if (v < mn) begin
      return mn[DataW-1:0];
    end
    return v[DataW-1:0];
  endfunction

endpackage

### hdl/dsf_front.sv
// front stages: end deltas, relative velocity, squares and their sum
// depends on dsf_pkg
module dsf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [31:0]          end1_x_i,
  input  logic signed [31:0]          end1_y_i,
  input  logic signed [31:0]          end2_x_i,
  input  logic signed [31:0]          end2_y_i,
  input  logic signed [31:0]          end1_vx_i,
  input  logic signed [31:0]          end1_vy_i,
  input  logic signed [31:0]          end2_vx_i,
  input  logic signed [31:0]          end2_vy_i,
  input  logic                        end1_fixed_i,
  input  logic                        end2_fixed_i,
  output logic                        valid_o,
  output dsf_pkg::dsf_side_t          side_o,
  output logic [dsf_pkg::SumW-1:0]    sum_o
);
  import dsf_pkg::*;

  logic signed [MagW-1:0] dx, dy;
  logic signed [RelW-1:0] v1x, v1y, v2x, v2y;
  dsf_side_t a_d, a_q, b_q, c_q;
  logic va_q, vb_q, vc_q;
  logic [SumW-1:0] sqx_q, sqy_q, sum_q;

  always_comb begin
    dx = $signed({end2_x_i[31], end2_x_i}) - $signed({end1_x_i[31], end1_x_i});
    dy = $signed({end2_y_i[31], end2_y_i}) - $signed({end1_y_i[31], end1_y_i});
    v1x = end1_fixed_i ? '0 : RelW'(end1_vx_i);
    v1y = end1_fixed_i ? '0 : RelW'(end1_vy_i);
    v2x = end2_fixed_i ? '0 : RelW'(end2_vx_i);
    v2y = end2_fixed_i ? '0 : RelW'(end2_vy_i);
    a_d.sx   = dx[MagW-1];
    a_d.sy   = dy[MagW-1];
    a_d.ax   = dx[MagW-1] ? MagW'(-dx) : MagW'(dx);
    a_d.ay   = dy[MagW-1] ? MagW'(-dy) : MagW'(dy);
    a_d.rvx  = v2x - v1x;
    a_d.rvy  = v2y - v1y;
    a_d.fix1 = end1_fixed_i;
    a_d.fix2 = end2_fixed_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_d;
      b_q   <= a_q;
      sqx_q <= a_q.ax * a_q.ax;
      sqy_q <= a_q.ay * a_q.ay;
      c_q   <= b_q;
      sum_q <= sqx_q + sqy_q;
    end
  end

  assign valid_o = vc_q;
  assign side_o  = c_q;
  assign sum_o   = sum_q;

endmodule

### hdl/dsf_isqrt.sv
// pipelined integer square root, one root bit per stage
// depends on dsf_pkg
module dsf_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  dsf_pkg::dsf_side_t        side_i,
  input  logic [dsf_pkg::SumW-1:0]  sum_i,
  output logic                      valid_o,
  output dsf_pkg::dsf_side_t        side_o,
  output logic [dsf_pkg::LenW-1:0]  len_o
);
  import dsf_pkg::*;

  localparam int unsigned Steps = LenW;
  localparam int unsigned RemW  = LenW + 3;

  logic [RemW-1:0] rem_q  [Steps];
  logic [LenW-1:0] root_q [Steps];
  logic [SumW-1:0] rad_q  [Steps];
  dsf_side_t       side_q [Steps];
  logic            vld_q  [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [RemW-1:0] prev_rem, cur, trial, rem_d;
    logic [LenW-1:0] prev_root, root_d;
    logic [SumW-1:0] prev_rad;
    dsf_side_t       prev_side;
    logic            prev_vld, ge;

    if (i == 0) begin : g_first
      always_comb begin
        prev_rem  = '0;
        prev_root = '0;
        prev_rad  = sum_i;
        prev_side = side_i;
        prev_vld  = valid_i;
      end
    end else begin : g_next
      always_comb begin
        prev_rem  = rem_q[i-1];
        prev_root = root_q[i-1];
        prev_rad  = rad_q[i-1];
        prev_side = side_q[i-1];
        prev_vld  = vld_q[i-1];
      end
    end

    always_comb begin
      cur    = {prev_rem[RemW-3:0], prev_rad[SumW-1-2*i -: 2]};
      trial  = RemW'({prev_root, 2'b01});
      ge     = cur >= trial;
      rem_d  = ge ? cur - trial : cur;
      root_d = {prev_root[LenW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        root_q[i] <= root_d;
        rad_q[i]  <= prev_rad;
        side_q[i] <= prev_side;
      end
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign side_o  = side_q[Steps-1];
  assign len_o   = root_q[Steps-1];

endmodule

### hdl/dsf_div.sv
// pipelined restoring dividers for the unit direction, one quotient bit per stage
// depends on dsf_pkg
module dsf_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  dsf_pkg::dsf_side_t       side_i,
  input  logic [dsf_pkg::LenW-1:0] len_i,
  output logic                     valid_o,
  output dsf_pkg::dsf_tail_t       tail_o,
  output logic [dsf_pkg::QW-1:0]   qx_o,
  output logic [dsf_pkg::QW-1:0]   qy_o
);
  import dsf_pkg::*;

  localparam int unsigned RemW = LenW + 1;

  logic [RemW-1:0] rx_q [QW];
  logic [RemW-1:0] ry_q [QW];
  logic [QW-1:0]   qx_q [QW];
  logic [QW-1:0]   qy_q [QW];
  dsf_tail_t       tl_q [QW];
  logic            vld_q[QW];

  dsf_tail_t tail_in;

  always_comb begin
    tail_in.sx   = side_i.sx;
    tail_in.sy   = side_i.sy;
    tail_in.rvx  = side_i.rvx;
    tail_in.rvy  = side_i.rvy;
    tail_in.fix1 = side_i.fix1;
    tail_in.fix2 = side_i.fix2;
    tail_in.len  = len_i;
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [RemW-1:0] prx, pry, cx, cy, dv;
    logic [QW-1:0]   pqx, pqy;
    dsf_tail_t       ptl;
    logic            pvld, nbx, nby, gx, gy;

    if (j == 0) begin : g_first
      always_comb begin
        prx  = RemW'(side_i.ax >> 1);
        pry  = RemW'(side_i.ay >> 1);
        pqx  = '0;
        pqy  = '0;
        ptl  = tail_in;
        pvld = valid_i;
        nbx  = side_i.ax[0];
        nby  = side_i.ay[0];
      end
    end else begin : g_next
      always_comb begin
        prx  = rx_q[j-1];
        pry  = ry_q[j-1];
        pqx  = qx_q[j-1];
        pqy  = qy_q[j-1];
        ptl  = tl_q[j-1];
        pvld = vld_q[j-1];
        nbx  = 1'b0;
        nby  = 1'b0;
      end
    end

    always_comb begin
      dv = (ptl.len < LenMin) ? RemW'(1) : RemW'(ptl.len);
      cx = {prx[RemW-2:0], nbx};
      cy = {pry[RemW-2:0], nby};
      gx = cx >= dv;
      gy = cy >= dv;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= pvld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[j] <= gx ? cx - dv : cx;
        ry_q[j] <= gy ? cy - dv : cy;
        qx_q[j] <= {pqx[QW-2:0], gx};
        qy_q[j] <= {pqy[QW-2:0], gy};
        tl_q[j] <= ptl;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign tail_o  = tl_q[QW-1];
  assign qx_o    = qx_q[QW-1];
  assign qy_o    = qy_q[QW-1];

endmodule

### hdl/dsf_back.sv
// back stages: stretch, spring and damping products, energy, saturation
// depends on dsf_pkg
module dsf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  dsf_pkg::dsf_tail_t        tail_i,
  input  logic [dsf_pkg::QW-1:0]    qx_i,
  input  logic [dsf_pkg::QW-1:0]    qy_i,
  input  dsf_pkg::dsf_cfg_t         cfg_i,
  output logic                      valid_o,
  output logic signed [31:0]        force_x_o,
  output logic signed [31:0]        force_y_o,
  output logic                      apply_end1_o,
  output logic                      apply_end2_o,
  output logic signed [31:0]        energy_o
);
  import dsf_pkg::*;

  localparam int unsigned UW   = QW + 1;
  localparam int unsigned StrW = LenW + 2;
  localparam int unsigned PW   = UW + StrW;
  localparam int unsigned TW   = PW - FracW;
  localparam int unsigned DmW  = RelW + DataW;
  localparam int unsigned DsW  = DmW - FracW;
  localparam int unsigned S2W  = 2 * StrW;
  localparam int unsigned SqW  = S2W - FracW;
  localparam int unsigned LoW  = 26;
  localparam int unsigned HiW  = SqW - LoW;
  localparam int unsigned SpW  = TW + DataW;
  localparam int unsigned EhW  = HiW + 1 + DataW;
  localparam int unsigned ElW  = LoW + 1 + DataW;
  localparam int unsigned EsW  = EhW + LoW + 1;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [1:0] fx1_q, fx2_q, fx3_q, fx4_q;

  // stage 1
  logic signed [UW-1:0]   ux_q, uy_q;
  logic signed [StrW-1:0] st_q;
  logic signed [RelW-1:0] rvx_q, rvy_q;
  logic signed [UW-1:0]   ux_d, uy_d;
  logic                   short_len;

  // stage 2
  logic signed [PW-1:0]   px_q, py_q;
  logic signed [DmW-1:0]  dx_q, dy_q;
  logic signed [S2W-1:0]  s2_q;

  // stage 3
  logic signed [TW-1:0]   tx_q, ty_q;
  logic signed [DsW-1:0]  dsx_q, dsy_q, dsx4_q, dsy4_q;
  logic [SqW-1:0]         sq_q;

  // stage 4
  logic signed [SpW-1:0]  spx_q, spy_q;
  logic signed [EhW-1:0]  eh_q;
  logic signed [ElW-1:0]  el_q;

  logic signed [SatW-1:0] fx_sum, fy_sum, e_sum;
  logic signed [EsW-1:0]  e_full;

  always_comb begin
    short_len = tail_i.len < LenMin;
    ux_d = tail_i.sx ? -$signed({1'b0, qx_i}) : $signed({1'b0, qx_i});
    uy_d = tail_i.sy ? -$signed({1'b0, qy_i}) : $signed({1'b0, qy_i});
    if (short_len) begin
      ux_d = '0;
      uy_d = '0;
    end
  end

  always_comb begin
    fx_sum = $signed({{(SatW-SpW+FracW){spx_q[SpW-1]}}, spx_q[SpW-1:FracW]})
           + $signed({{(SatW-DsW){dsx4_q[DsW-1]}}, dsx4_q});
    fy_sum = $signed({{(SatW-SpW+FracW){spy_q[SpW-1]}}, spy_q[SpW-1:FracW]})
           + $signed({{(SatW-DsW){dsy4_q[DsW-1]}}, dsy4_q});
    e_full = $signed({{(EsW-EhW-LoW){eh_q[EhW-1]}}, eh_q, {LoW{1'b0}}})
           + $signed({{(EsW-ElW){el_q[ElW-1]}}, el_q});
    e_sum  = $signed({{(SatW-EsW+FracW+1){e_full[EsW-1]}}, e_full[EsW-1:FracW+1]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q   <= ux_d;
      uy_q   <= uy_d;
      st_q   <= $signed({2'b00, tail_i.len}) - $signed({{(StrW-RestW){1'b0}}, cfg_i.rest});
      rvx_q  <= tail_i.rvx;
      rvy_q  <= tail_i.rvy;
      fx1_q  <= {tail_i.fix2, tail_i.fix1};

      px_q   <= ux_q * st_q;
      py_q   <= uy_q * st_q;
      dx_q   <= rvx_q * cfg_i.kd;
      dy_q   <= rvy_q * cfg_i.kd;
      s2_q   <= st_q * st_q;
      fx2_q  <= fx1_q;

      tx_q   <= $signed(px_q[PW-1:FracW]);
      ty_q   <= $signed(py_q[PW-1:FracW]);
      dsx_q  <= $signed(dx_q[DmW-1:FracW]);
      dsy_q  <= $signed(dy_q[DmW-1:FracW]);
      sq_q   <= s2_q[S2W-1:FracW];
      fx3_q  <= fx2_q;

      spx_q  <= tx_q * cfg_i.ks;
      spy_q  <= ty_q * cfg_i.ks;
      eh_q   <= $signed({1'b0, sq_q[SqW-1:LoW]}) * cfg_i.ks;
      el_q   <= $signed({1'b0, sq_q[LoW-1:0]}) * cfg_i.ks;
      dsx4_q <= dsx_q;
      dsy4_q <= dsy_q;
      fx4_q  <= fx3_q;

      force_x_o    <= sat_out(fx_sum);
      force_y_o    <= sat_out(fy_sum);
      energy_o     <= sat_out(e_sum);
      apply_end1_o <= !fx4_q[0];
      apply_end2_o <= !fx4_q[1];
    end
  end

  assign valid_o = v5_q;

endmodule

### hdl/damped_spring_force_2d.sv
// Damped Hookean spring force in the plane, Q16.16 in and out. One beat is
// accepted every cycle while the pipeline is not halted, and each beat gives
// exactly one result beat, passing 3 front stages (delta, square, sum), 33 square
// root stages (one root bit each), 17 divider stages (one direction bit each) and
// 5 back stages of multiplies and saturation. The whole pipeline advances as one;
// it halts only while the output beat is held by out_ready_i low. Configuration
// is an APB slave at byte addresses 0 (rest length), 4 (stiffness) and 8 (damping).
// depends on dsf_pkg, dsf_front, dsf_isqrt, dsf_div, dsf_back
module damped_spring_force_2d (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dsf_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [31:0]            end1_x_i,
  input  logic signed [31:0]            end1_y_i,
  input  logic signed [31:0]            end2_x_i,
  input  logic signed [31:0]            end2_y_i,
  input  logic signed [31:0]            end1_vx_i,
  input  logic signed [31:0]            end1_vy_i,
  input  logic signed [31:0]            end2_vx_i,
  input  logic signed [31:0]            end2_vy_i,
  input  logic                          end1_fixed_i,
  input  logic                          end2_fixed_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            force_x_o,
  output logic signed [31:0]            force_y_o,
  output logic                          apply_end1_o,
  output logic                          apply_end2_o,
  output logic signed [31:0]            energy_o
);
  import dsf_pkg::*;

  dsf_cfg_t cfg_q;
  logic [1:0] reg_idx;
  logic en, fv, sv, dv;
  dsf_side_t f_side, s_side;
  dsf_tail_t d_tail;
  logic [SumW-1:0] f_sum;
  logic [LenW-1:0] s_len;
  logic [QW-1:0] qx, qy;

  assign reg_idx = paddr[AddrW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest <= RestW'(1 << FracW);
      cfg_q.ks   <= DataW'(1 << FracW);
      cfg_q.kd   <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegRest:  cfg_q.rest <= pwdata[RestW-1:0];
        RegStiff: cfg_q.ks   <= $signed(pwdata);
        RegDamp:  cfg_q.kd   <= $signed(pwdata);
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegRest:  prdata = {1'b0, cfg_q.rest};
      RegStiff: prdata = cfg_q.ks;
      RegDamp:  prdata = cfg_q.kd;
      default:  prdata = '0;
    endcase
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  dsf_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .end1_x_i, .end1_y_i, .end2_x_i, .end2_y_i,
    .end1_vx_i, .end1_vy_i, .end2_vx_i, .end2_vy_i,
    .end1_fixed_i, .end2_fixed_i,
    .valid_o(fv), .side_o(f_side), .sum_o(f_sum)
  );

  dsf_isqrt u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fv), .side_i(f_side), .sum_i(f_sum),
    .valid_o(sv), .side_o(s_side), .len_o(s_len)
  );

  dsf_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sv), .side_i(s_side), .len_i(s_len),
    .valid_o(dv), .tail_o(d_tail), .qx_o(qx), .qy_o(qy)
  );

  dsf_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv), .tail_i(d_tail),
    .qx_i(qx), .qy_i(qy), .cfg_i(cfg_q),
    .valid_o(out_valid_o), .force_x_o, .force_y_o,
    .apply_end1_o, .apply_end2_o, .energy_o
  );

endmodule

### tb/damped_spring_force_2d_tb.sv
// self-checking testbench for damped_spring_force_2d: directed rows, then random beats
// over several register settings and handshake idling patterns, checked against a predictor
// depends on dsf_pkg and the damped_spring_force_2d rtl
module damped_spring_force_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsf_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [31:0] x1, y1, x2, y2, vx1, vy1, vx2, vy2;
    logic               fix1, fix2;
  } spring_in_t;

  typedef struct packed {
    logic signed [31:0] fx, fy;
    logic               ap1, ap2;
    logic signed [31:0] en;
  } spring_out_t;

  typedef struct packed {
    spring_in_t  stim;
    logic        typed;
    spring_out_t res;
  } row_t;

  localparam logic [1:0] RegSpare = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  spring_in_t beat_q = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] force_x_o, force_y_o, energy_o;
  logic apply_end1_o, apply_end2_o;

  logic [30:0]        rest_len = 31'd65536;
  logic signed [31:0] ks = 32'sd65536;
  logic signed [31:0] kd = 32'sd0;

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  spring_out_t force_fifo[$];

  damped_spring_force_2d dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .end1_x_i(beat_q.x1), .end1_y_i(beat_q.y1), .end2_x_i(beat_q.x2), .end2_y_i(beat_q.y2),
    .end1_vx_i(beat_q.vx1), .end1_vy_i(beat_q.vy1),
    .end2_vx_i(beat_q.vx2), .end2_vy_i(beat_q.vy2),
    .end1_fixed_i(beat_q.fix1), .end2_fixed_i(beat_q.fix2),
    .out_valid_o, .out_ready_i,
    .force_x_o, .force_y_o, .apply_end1_o, .apply_end2_o, .energy_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #200000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic wide_t mul_floor(wide_t a, wide_t b, int sh);
    wide_t p;
    wide_t lim;
    lim = wide_t'(1) <<< 62;
    p = (a * b) >>> sh;
    if (p > lim) p = lim;
    if (p < -lim) p = -lim;
    return p;
  endfunction

  function automatic logic signed [31:0] sat32(wide_t v);
    if (v > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -wide_t'(64'sh80000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic wide_t unit_part(wide_t d, wide_t len);
    wide_t q;
    q = ((d < 0 ? -d : d) <<< FracW) / len;
    return d < 0 ? -q : q;
  endfunction

  function automatic spring_out_t spring_force(spring_in_t b);
    spring_out_t r;
    wide_t dx, dy, sum, len, c, ux, uy, stretch, rvx, rvy, fx, fy, s2;
    dx = wide_t'(b.x2) - wide_t'(b.x1);
    dy = wide_t'(b.y2) - wide_t'(b.y1);
    sum = dx * dx + dy * dy;
    len = 0;
    for (int i = 34; i >= 0; i--) begin
      c = len | (wide_t'(1) <<< i);
      if (c * c <= sum) len = c;
    end
    ux = 0;
    uy = 0;
    if (len >= 656) begin
      ux = unit_part(dx, len);
      uy = unit_part(dy, len);
    end
    stretch = len - wide_t'({1'b0, rest_len});
    rvx = (b.fix2 ? wide_t'(0) : wide_t'(b.vx2)) - (b.fix1 ? wide_t'(0) : wide_t'(b.vx1));
    rvy = (b.fix2 ? wide_t'(0) : wide_t'(b.vy2)) - (b.fix1 ? wide_t'(0) : wide_t'(b.vy1));
    fx = mul_floor(mul_floor(ux, stretch, FracW), ks, FracW) + mul_floor(rvx, kd, FracW);
    fy = mul_floor(mul_floor(uy, stretch, FracW), ks, FracW) + mul_floor(rvy, kd, FracW);
    s2 = mul_floor(stretch, stretch, FracW);
    r.fx = sat32(fx);
    r.fy = sat32(fy);
    r.ap1 = !b.fix1;
    r.ap2 = !b.fix2;
    r.en = sat32(mul_floor(s2, ks, FracW + 1));
    return r;
  endfunction

  task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    spring_out_t want;
    if (out_valid_o && out_ready_i) begin
      if (force_fifo.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        errors++;
      end else begin
        want = force_fifo.pop_front();
        if (force_x_o !== want.fx) report("force_x", force_x_o, want.fx);
        if (force_y_o !== want.fy) report("force_y", force_y_o, want.fy);
        if (apply_end1_o !== want.ap1) report("apply_end1", apply_end1_o, want.ap1);
        if (apply_end2_o !== want.ap2) report("apply_end2", apply_end2_o, want.ap2);
        if (energy_o !== want.en) report("energy", energy_o, want.en);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegRest:  rest_len = val[30:0];
      RegStiff: ks = val;
      RegDamp:  kd = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_beat(spring_in_t b, logic typed, spring_out_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    beat_q <= b;
    do @(posedge clk_i); while (!in_ready_o);
    force_fifo.push_back(typed ? res : spring_force(b));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (force_fifo.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rnd_coord(int kind);
    case (kind)
      0: return $signed($urandom);
      1: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  function automatic spring_in_t rnd_beat();
    spring_in_t b;
    int kind;
    kind = $urandom_range(0, 9) < 3 ? 0 : ($urandom_range(0, 4) == 0 ? 1 : 2);
    b.x1 = rnd_coord(kind);
    b.y1 = rnd_coord(kind);
    b.x2 = kind == 0 ? rnd_coord(0) : b.x1 + rnd_coord(kind);
    b.y2 = kind == 0 ? rnd_coord(0) : b.y1 + rnd_coord(kind);
    b.vx1 = rnd_coord($urandom_range(0, 2));
    b.vy1 = rnd_coord($urandom_range(0, 2));
    b.vx2 = rnd_coord($urandom_range(0, 2));
    b.vy2 = rnd_coord($urandom_range(0, 2));
    b.fix1 = $urandom_range(0, 3) == 0;
    b.fix2 = $urandom_range(0, 3) == 0;
    return b;
  endfunction

  initial begin
    row_t rows[$];
    logic [31:0] cfg_rest[8];
    logic [31:0] cfg_ks[8];
    logic [31:0] cfg_kd[8];
    rows = '{
      '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0},
        1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b1, 32'sd32768}},
      '{'{32'sd0, 32'sd0, 32'sd131072, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0},
        1'b1, '{32'sd65536, 32'sd0, 1'b1, 1'b1, 32'sd32768}},
      '{'{32'sd0, 32'sd0, 32'sd0, 32'sd131072, 32'sd5, 32'sd7, 32'sd9, 32'sd3, 1'b1, 1'b1},
        1'b1, '{32'sd0, 32'sd65536, 1'b0, 1'b0, 32'sd32768}},
      '{'{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
          32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0, 1'b0},
        1'b0, '0},
      '{'{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
          32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1'b1, 1'b0},
        1'b0, '0},
      '{'{32'sd0, 32'sd0, 32'sd655, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b1},
        1'b0, '0},
      '{'{32'sd0, 32'sd0, 32'sd656, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0},
        1'b0, '0},
      '{'{32'sd10, 32'sd10, 32'sd10, 32'sd10, -32'sd1, 32'sd1, 32'sd1, -32'sd1, 1'b0, 1'b0},
        1'b0, '0},
      '{'{32'sd0, 32'sd0, -32'sd400, 32'sd463, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0},
        1'b0, '0}
    };
    cfg_rest = '{32'd65536, 32'd0, 32'h7fffffff, 32'd0, 32'd200000, 32'h7fffffff, 32'd65536,
                 32'd1000};
    cfg_ks = '{32'd65536, 32'h7fffffff, 32'h80000000, 32'd0, 32'hfffe0000, 32'd300000,
               32'h7fffffff, 32'd7};
    cfg_kd = '{32'd0, 32'h80000000, 32'h7fffffff, 32'd65536, 32'd32768, 32'hffff0000,
               32'h7fffffff, 32'h80000000};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_beat(rows[i].stim, rows[i].typed, rows[i].res);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      if (ph == 7) begin
        cfg_rest[ph] = $urandom;
        cfg_ks[ph] = $urandom;
        cfg_kd[ph] = $urandom;
      end
      write_reg(RegRest, cfg_rest[ph]);
      write_reg(RegStiff, cfg_ks[ph]);
      write_reg(RegDamp, cfg_kd[ph]);
      if (ph == 3) write_reg(RegSpare, 32'hffffffff);
      for (int n = 0; n < 192; n++) send_beat(rnd_beat(), 1'b0, '0);
      drain();
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### damped_spring_force_2d.f
hdl/dsf_pkg.sv
hdl/dsf_front.sv
hdl/dsf_isqrt.sv
hdl/dsf_div.sv
hdl/dsf_back.sv
hdl/damped_spring_force_2d.sv
tb/damped_spring_force_2d_tb.sv
